// File: rtl/qpc_pkg.sv
// Shared constants and types for the quad plausibility check block.
// Holds coordinate format, datapath widths, register map and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpc_pkg;

  localparam int CoordFracBits = 4;
  localparam int CoordW        = 16;
  localparam int DiffW         = CoordW + 1;
  localparam int SqW           = 2 * CoordW;
  localparam int CrossW        = 2 * CoordW + 1;
  localparam int LenW          = 2 * CoordW + 1;
  localparam int DotSumW       = LenW + 1;
  localparam int DotW          = LenW;
  localparam int SplitLo       = LenW / 2;
  localparam int SplitHi       = LenW - SplitLo;
  localparam int WideW         = 2 * LenW;
  localparam int CmpW          = WideW + 2;

  localparam int PixW          = 11;
  localparam int RatioW        = 4;
  localparam int MarginW       = 8;
  localparam int MinSqW        = 2 * PixW;
  localparam int RatioSqW      = 2 * RatioW;
  localparam int RatioProdW    = RatioSqW + LenW;

  localparam int NumCorners    = 4;
  localparam int InDataW       = 2 * NumCorners * CoordW;
  localparam int OutDataW      = 8;
  localparam int CfgDataW      = 32;
  localparam int CfgAddrW      = 5;

  typedef enum logic [2:0] {
    RegImageWidth   = 3'd0,
    RegImageHeight  = 3'd1,
    RegMinEdgeLen   = 3'd2,
    RegMaxEdgeRatio = 3'd3,
    RegOrderMargin  = 3'd4
  } cfg_idx_t;

  localparam logic [PixW-1:0]    ImageWidthRst   = 11'd640;
  localparam logic [PixW-1:0]    ImageHeightRst  = 11'd480;
  localparam logic [PixW-1:0]    MinEdgeLenRst   = 11'd20;
  localparam logic [RatioW-1:0]  MaxEdgeRatioRst = 4'd7;
  localparam logic [MarginW-1:0] OrderMarginRst  = 8'd5;

  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic        [LenW-1:0]   len_t;
  typedef logic        [WideW-1:0]  wide_t;

endpackage

`default_nettype wire

// File: rtl/quad_plausibility_check_unit.sv
// Quad plausibility check: length, angle and corner-order flags per quad.
// Six-stage pipeline with APB register file; depends on qpc_pkg.
// Exact integer arithmetic, squared lengths and cosines.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------
//  in_      | slave     | in_tvalid / in_tready     | 8 x 16-bit signed corner coords
//  out_     | master    | out_tvalid / out_tready   | length, angle, order, all flags
//  cfg_     | APB slave | psel, penable, pready     | 5 registers, 32-bit data
//
// One request enters per cycle while out_tready does not stall the pipeline; its flags
// are registered in stage 6 and held on out_ until out_tready takes them.
// The split 33x33 angle products span stages 4 and 5 (partial products, then sum).
// rst_n is synchronous; it clears stage valid bits and loads register defaults.
// A stall holds each full stage; empty stages keep filling, so bubbles collapse.
`timescale 1ns / 1ps
`default_nettype none

module quad_plausibility_check_unit
  import qpc_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // [15:0] top_left_x, [31:16] top_left_y, [47:32] top_right_x,
  // [63:48] top_right_y, [79:64] bottom_right_x, [95:80] bottom_right_y,
  // [111:96] bottom_left_x, [127:112] bottom_left_y
  input  wire  [InDataW-1:0]         in_tdata,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // [0] length_ok, [1] angle_ok, [2] order_ok, [3] all_ok, [7:4] zero
  output logic [OutDataW-1:0]        out_tdata,
  input  wire                        cfg_psel,
  input  wire                        cfg_penable,
  input  wire                        cfg_pwrite,
  input  wire  [CfgAddrW-1:0]        cfg_paddr,
  input  wire  [CfgDataW-1:0]        cfg_pwdata,
  output logic [CfgDataW-1:0]        cfg_prdata,
  output logic                       cfg_pready
);

  // configuration registers
  logic [PixW-1:0]    img_w_r, img_h_r, min_len_r;
  logic [RatioW-1:0]  ratio_r;
  logic [MarginW-1:0] margin_r;
  cfg_idx_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[CfgAddrW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= ImageWidthRst;
      img_h_r   <= ImageHeightRst;
      min_len_r <= MinEdgeLenRst;
      ratio_r   <= MaxEdgeRatioRst;
      margin_r  <= OrderMarginRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegImageWidth:   img_w_r   <= cfg_pwdata[PixW-1:0];
        RegImageHeight:  img_h_r   <= cfg_pwdata[PixW-1:0];
        RegMinEdgeLen:   min_len_r <= cfg_pwdata[PixW-1:0];
        RegMaxEdgeRatio: ratio_r   <= cfg_pwdata[RatioW-1:0];
        RegOrderMargin:  margin_r  <= cfg_pwdata[MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegImageWidth:   cfg_prdata = CfgDataW'(img_w_r);
      RegImageHeight:  cfg_prdata = CfgDataW'(img_h_r);
      RegMinEdgeLen:   cfg_prdata = CfgDataW'(min_len_r);
      RegMaxEdgeRatio: cfg_prdata = CfgDataW'(ratio_r);
      RegOrderMargin:  cfg_prdata = CfgDataW'(margin_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6      = !v6_r || out_tready;
  assign rdy5      = !v5_r || rdy6;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: edge deltas, order test
  logic signed [CoordW-1:0] cx [NumCorners];
  logic signed [CoordW-1:0] cy [NumCorners];
  diff_t                    ex_nxt [NumCorners];
  diff_t                    ey_nxt [NumCorners];
  diff_t                    ex_r   [NumCorners];
  diff_t                    ey_r   [NumCorners];
  logic [MarginW+CoordFracBits-1:0] mg;
  logic [PixW+CoordFracBits-1:0]    w_s, h_s;
  diff_t                    mg_x;
  logic [NumCorners-1:0]    outside;
  logic                     ord_nxt, s1_ord_r;

  always_comb begin
    mg   = {margin_r, CoordFracBits'(0)};
    w_s  = {img_w_r, CoordFracBits'(0)};
    h_s  = {img_h_r, CoordFracBits'(0)};
    mg_x = $signed({{(DiffW-MarginW-CoordFracBits){1'b0}}, mg});
    for (int i = 0; i < NumCorners; i++) begin
      cx[i] = in_tdata[2*i*CoordW +: CoordW];
      cy[i] = in_tdata[(2*i+1)*CoordW +: CoordW];
    end
    for (int i = 0; i < NumCorners; i++) begin
      ex_nxt[i] = DiffW'(cx[(i+1)%NumCorners]) - DiffW'(cx[i]);
      ey_nxt[i] = DiffW'(cy[(i+1)%NumCorners]) - DiffW'(cy[i]);
      outside[i] = cx[i][CoordW-1] || cy[i][CoordW-1] ||
                   ($signed(cx[i]) > $signed(CoordW'(w_s))) ||
                   ($signed(cy[i]) > $signed(CoordW'(h_s)));
    end
    ord_nxt = !((DiffW'(cy[0]) + mg_x) >= DiffW'(cy[3]) ||
                (DiffW'(cy[1]) + mg_x) >= DiffW'(cy[2]) ||
                (DiffW'(cx[0]) + mg_x) >= DiffW'(cx[1]) ||
                (DiffW'(cx[3]) + mg_x) >= DiffW'(cx[2])) &&
              !(&outside);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
      s1_ord_r <= ord_nxt;
    end
  end

  // stage 2: squares and dot-product terms
  logic [SqW-1:0]           sqx_nxt [NumCorners];
  logic [SqW-1:0]           sqy_nxt [NumCorners];
  logic signed [CrossW-1:0] crx_nxt [NumCorners];
  logic signed [CrossW-1:0] cry_nxt [NumCorners];
  logic [SqW-1:0]           sqx_r   [NumCorners];
  logic [SqW-1:0]           sqy_r   [NumCorners];
  logic signed [CrossW-1:0] crx_r   [NumCorners];
  logic signed [CrossW-1:0] cry_r   [NumCorners];
  logic signed [2*DiffW-1:0] pxx, pyy, pcx, pcy;
  logic                     s2_ord_r;

  always_comb begin
    for (int i = 0; i < NumCorners; i++) begin
      pxx        = ex_r[i] * ex_r[i];
      pyy        = ey_r[i] * ey_r[i];
      pcx        = ex_r[(i+3)%NumCorners] * ex_r[i];
      pcy        = ey_r[(i+3)%NumCorners] * ey_r[i];
      sqx_nxt[i] = pxx[SqW-1:0];
      sqy_nxt[i] = pyy[SqW-1:0];
      crx_nxt[i] = pcx[CrossW-1:0];
      cry_nxt[i] = pcy[CrossW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      crx_r    <= crx_nxt;
      cry_r    <= cry_nxt;
      s2_ord_r <= s1_ord_r;
    end
  end

  // stage 3: squared lengths, dot products, config squares
  len_t                     len_nxt  [NumCorners];
  logic [DotW-1:0]          dmag_nxt [NumCorners];
  logic [NumCorners-1:0]    dpos_nxt;
  len_t                     len_r    [NumCorners];
  logic [DotW-1:0]          dmag_r   [NumCorners];
  logic [NumCorners-1:0]    s3_dpos_r;
  logic signed [DotSumW-1:0] dsum;
  logic [MinSqW-1:0]        minsq_nxt, minsq_r;
  logic [RatioSqW-1:0]      rsq_nxt, s3_rsq_r;
  logic                     s3_ord_r;

  always_comb begin
    for (int i = 0; i < NumCorners; i++) begin
      len_nxt[i]  = LenW'(sqx_r[i]) + LenW'(sqy_r[i]);
      dsum        = DotSumW'(crx_r[i]) + DotSumW'(cry_r[i]);
      dpos_nxt[i] = dsum[DotSumW-1];
      dmag_nxt[i] = DotW'(-dsum);
    end
    minsq_nxt = MinSqW'(min_len_r) * MinSqW'(min_len_r);
    rsq_nxt   = RatioSqW'(ratio_r) * RatioSqW'(ratio_r);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      len_r     <= len_nxt;
      dmag_r    <= dmag_nxt;
      s3_dpos_r <= dpos_nxt;
      minsq_r   <= minsq_nxt;
      s3_rsq_r  <= rsq_nxt;
      s3_ord_r  <= s2_ord_r;
    end
  end

  // stage 4: partial products, min/max, short-edge test
  logic [2*SplitHi-1:0]       dhh_nxt [NumCorners], dhh_r [NumCorners];
  logic [SplitHi+SplitLo-1:0] dhl_nxt [NumCorners], dhl_r [NumCorners];
  logic [2*SplitLo-1:0]       dll_nxt [NumCorners], dll_r [NumCorners];
  logic [2*SplitHi-1:0]       lhh_nxt [NumCorners], lhh_r [NumCorners];
  logic [SplitHi+SplitLo-1:0] lhl_nxt [NumCorners], lhl_r [NumCorners];
  logic [SplitHi+SplitLo-1:0] llh_nxt [NumCorners], llh_r [NumCorners];
  logic [2*SplitLo-1:0]       lll_nxt [NumCorners], lll_r [NumCorners];
  logic [SplitHi-1:0]         dh, ph, ch;
  logic [SplitLo-1:0]         dl, pl, cl;
  len_t                       min01, min23, max01, max23;
  len_t                       lmin_nxt, lmax_nxt, lmin_r, s4_lmax_r;
  logic [LenW-1:0]            minsq_s;
  logic                       short_nxt, s4_short_r;
  logic [NumCorners-1:0]      s4_dpos_r;
  logic [RatioSqW-1:0]        s4_rsq_r;
  logic                       s4_ord_r;

  always_comb begin
    minsq_s   = LenW'({minsq_r, (2*CoordFracBits)'(0)});
    short_nxt = 1'b0;
    for (int i = 0; i < NumCorners; i++) begin
      dh = dmag_r[i][LenW-1:SplitLo];
      dl = dmag_r[i][SplitLo-1:0];
      ph = len_r[(i+3)%NumCorners][LenW-1:SplitLo];
      pl = len_r[(i+3)%NumCorners][SplitLo-1:0];
      ch = len_r[i][LenW-1:SplitLo];
      cl = len_r[i][SplitLo-1:0];
      dhh_nxt[i] = (2*SplitHi)'(dh) * (2*SplitHi)'(dh);
      dhl_nxt[i] = (SplitHi+SplitLo)'(dh) * (SplitHi+SplitLo)'(dl);
      dll_nxt[i] = (2*SplitLo)'(dl) * (2*SplitLo)'(dl);
      lhh_nxt[i] = (2*SplitHi)'(ph) * (2*SplitHi)'(ch);
      lhl_nxt[i] = (SplitHi+SplitLo)'(ph) * (SplitHi+SplitLo)'(cl);
      llh_nxt[i] = (SplitHi+SplitLo)'(pl) * (SplitHi+SplitLo)'(ch);
      lll_nxt[i] = (2*SplitLo)'(pl) * (2*SplitLo)'(cl);
      if (len_r[i] < minsq_s) short_nxt = 1'b1;
    end
    min01    = (len_r[1] < len_r[0]) ? len_r[1] : len_r[0];
    min23    = (len_r[3] < len_r[2]) ? len_r[3] : len_r[2];
    max01    = (len_r[1] > len_r[0]) ? len_r[1] : len_r[0];
    max23    = (len_r[3] > len_r[2]) ? len_r[3] : len_r[2];
    lmin_nxt = (min23 < min01) ? min23 : min01;
    lmax_nxt = (max23 > max01) ? max23 : max01;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      dhh_r      <= dhh_nxt;
      dhl_r      <= dhl_nxt;
      dll_r      <= dll_nxt;
      lhh_r      <= lhh_nxt;
      lhl_r      <= lhl_nxt;
      llh_r      <= llh_nxt;
      lll_r      <= lll_nxt;
      lmin_r     <= lmin_nxt;
      s4_lmax_r  <= lmax_nxt;
      s4_short_r <= short_nxt;
      s4_dpos_r  <= s3_dpos_r;
      s4_rsq_r   <= s3_rsq_r;
      s4_ord_r   <= s3_ord_r;
    end
  end

  // stage 5: sum partial products, ratio bound
  wide_t                   dsq_nxt [NumCorners], dsq_r [NumCorners];
  wide_t                   lpr_nxt [NumCorners], lpr_r [NumCorners];
  logic [RatioProdW-1:0]   rprod_nxt, rprod_r;
  len_t                    s5_lmax_r;
  logic                    s5_short_r;
  logic [NumCorners-1:0]   s5_dpos_r;
  logic                    s5_ord_r;

  always_comb begin
    for (int i = 0; i < NumCorners; i++) begin
      dsq_nxt[i] = (WideW'(dhh_r[i]) << (2*SplitLo)) +
                   (WideW'(dhl_r[i]) << (SplitLo+1)) + WideW'(dll_r[i]);
      lpr_nxt[i] = (WideW'(lhh_r[i]) << (2*SplitLo)) +
                   ((WideW'(lhl_r[i]) + WideW'(llh_r[i])) << SplitLo) +
                   WideW'(lll_r[i]);
    end
    rprod_nxt = RatioProdW'(s4_rsq_r) * RatioProdW'(lmin_r);
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      dsq_r      <= dsq_nxt;
      lpr_r      <= lpr_nxt;
      rprod_r    <= rprod_nxt;
      s5_lmax_r  <= s4_lmax_r;
      s5_short_r <= s4_short_r;
      s5_dpos_r  <= s4_dpos_r;
      s5_ord_r   <= s4_ord_r;
    end
  end

  // stage 6: final compares into output register
  logic [CmpW-1:0] lhs, rhs;
  logic            len_ok_nxt, ang_ok_nxt;
  logic            len_ok_r, ang_ok_r, ord_ok_r;

  always_comb begin
    ang_ok_nxt = 1'b1;
    for (int i = 0; i < NumCorners; i++) begin
      lhs = {dsq_r[i], 2'b00};
      rhs = CmpW'(lpr_r[i]) + {lpr_r[i], 1'b0};
      if (s5_dpos_r[i] && (lhs > rhs)) ang_ok_nxt = 1'b0;
    end
    len_ok_nxt = !s5_short_r && !(RatioProdW'(s5_lmax_r) > rprod_r);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      len_ok_r <= len_ok_nxt;
      ang_ok_r <= ang_ok_nxt;
      ord_ok_r <= s5_ord_r;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = {4'b0000, len_ok_r && ang_ok_r && ord_ok_r, ord_ok_r, ang_ok_r,
                       len_ok_r};

`ifndef SYNTH
  // back-pressure only when every stage holds a request
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && v5_r && v6_r))
    else $error("input stalled with an empty pipeline stage");

  // a stalled stage keeps its request and payload
  a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !rdy5) |=> (v5_r && $stable(s5_lmax_r) && $stable(rprod_r)))
    else $error("stage 5 lost or changed a stalled request");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire
